### src/swli_pkg.sv
// Shared constants for the sample window linear interpolator.
`default_nettype none
package swli_pkg;

    localparam int DEF_MAX_ELEMENTS = 8;

    localparam int TW     = 48;   // time width
    localparam int VW     = 48;   // element width
    localparam int FW     = 49;   // distance width
    localparam int SW     = 98;   // blended sum width
    localparam int ACC_W  = 145;  // product accumulator width
    localparam int DIGITS = 6;    // 8-bit multiplier digits per 48-bit operand

    // fetch phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_RESET     = 3'd1;
    localparam logic [2:0] PH_LO_INTERP = 3'd2;
    localparam logic [2:0] PH_LO_SHIFT  = 3'd3;
    localparam logic [2:0] PH_UP_INTERP = 3'd4;
    localparam logic [2:0] PH_UP_SHIFT  = 3'd5;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_LDA  = 3'd2;
    localparam logic [2:0] ST_LDB  = 3'd3;
    localparam logic [2:0] ST_M1   = 3'd4;
    localparam logic [2:0] ST_M2   = 3'd5;
    localparam logic [2:0] ST_M3   = 3'd6;

    // emission modes
    localparam logic [1:0] MD_RAW = 2'd0;
    localparam logic [1:0] MD_LOW = 2'd1;
    localparam logic [1:0] MD_UP  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ELEMENT_COUNT = 2'd0;
    localparam logic [1:0] CFG_STEP_SIZE     = 2'd1;
    localparam logic [1:0] CFG_STEP_RECIP    = 2'd2;

    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_ELEMENT = 1'b1;

    // window roles, also valid bit positions
    localparam int ROLE_LOW = 0;
    localparam int ROLE_CEN = 1;
    localparam int ROLE_UP  = 2;

    localparam logic [3:0]  RST_ELEMENT_COUNT = 4'd6;
    localparam logic [46:0] RST_STEP_SIZE     = 47'd16777216;
    localparam logic [47:0] RST_STEP_RECIP    = 48'd4294967296;

endpackage
`default_nettype wire

### src/sample_window_linear_interpolator.sv
// Top level of the sample window linear interpolator.
//
// Channel   Dir  Handshake                 Payload
// input     in   start & ~busy             i_opcode, i_query_time, i_sample_element
// result    out  o_strobe (one cycle)      o_result_kind, o_request_time,
//                                          o_element_value, o_element_index, o_last
// config    in   i_cfg_valid & o_cfg_ready i_cfg_index, i_cfg_data
//
// Requests leave in the cycle after the accepting edge; sample items and requests
// are taken only while busy is low. Per element, an answer run makes a memory read of
// each neighbour (one read port, registered) and three 6-digit passes of the shared
// 8-bit-digit multiplier; raw answers make one memory read per element. busy is high
// for the whole run. Synchronous active-low reset clears the window to empty;
// the sample memory is not cleared. Results cannot be stalled.
`default_nettype none
module sample_window_linear_interpolator
    import swli_pkg::*;
#(
    parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_opcode,
    input  wire logic signed [47:0] i_query_time,
    input  wire logic signed [47:0] i_sample_element,
    output logic                    o_strobe,
    output logic                    o_result_kind,
    output logic signed [47:0]      o_request_time,
    output logic signed [47:0]      o_element_value,
    output logic [2:0]              o_element_index,
    output logic                    o_last,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [47:0]        i_cfg_data
);

    localparam int LIMIT = (MAX_ELEMENTS < 8) ? MAX_ELEMENTS : 8;
    localparam int DEPTH = 3 * MAX_ELEMENTS;
    localparam int AW    = $clog2(DEPTH);

    // configuration
    logic [3:0]  r_element_count, n_element_count;
    logic [46:0] r_step, n_step;
    logic [47:0] r_recip, n_recip;

    // window state
    logic [TW-1:0] r_lower, n_lower, r_center, n_center, r_upper, n_upper;
    logic [TW-1:0] r_pending, n_pending;
    logic [2:0]    r_valid, n_valid;
    logic [1:0]    r_slot_lo, n_slot_lo, r_slot_ce, n_slot_ce, r_slot_up, n_slot_up;
    logic [2:0]    r_phase, n_phase;
    logic [2:0]    r_cnt, n_cnt;

    // answer sequencer
    logic [2:0]  r_state, n_state;
    logic [1:0]  r_mode, n_mode;
    logic [2:0]  r_elem, n_elem;
    logic [2:0]  r_dcnt, n_dcnt;
    logic signed [FW-1:0] r_fa, n_fa, r_fb, n_fb;
    logic [VW-1:0]    r_ea, n_ea, r_eb, n_eb;
    logic [ACC_W-1:0] r_mcand, n_mcand, r_acc, n_acc;
    logic [47:0]      r_mplier, n_mplier;
    logic [SW-1:0]    r_s, n_s;

    // result register
    logic        r_strobe, n_strobe;
    logic        r_kind, n_kind;
    logic [47:0] r_req_time, n_req_time, r_value, n_value;
    logic [2:0]  r_index, n_index;
    logic        r_last, n_last;

    // sample memory
    logic [VW-1:0] r_sample_mem [0:DEPTH-1];
    logic [VW-1:0] r_rd_data;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;

    // helpers
    logic [3:0]  cnt_eff;
    logic        last_elem;
    logic signed [49:0] t50, c50, d50, lo1, lo2, up1, up2;
    logic [TW-1:0] sh_lower, sh_upper;
    logic        do_req, do_emit, do_shdn, do_shup;
    logic [2:0]  req_phase;
    logic [TW-1:0] req_time;
    logic [1:0]  emit_mode;
    logic [1:0]  fetch_slot, slot_a, slot_b;
    logic [2:0]  fetch_bit;
    logic [ACC_W-1:0] acc_sum;
    logic [SW-1:0] term, s2, abs_s;
    logic [47:0] q;
    logic        over;
    logic [47:0] res;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe        = r_strobe;
    assign o_result_kind   = r_kind;
    assign o_request_time  = r_req_time;
    assign o_element_value = r_value;
    assign o_element_index = r_index;
    assign o_last          = r_last;

    always_comb begin
        if (r_element_count == 4'd0) begin
            cnt_eff = 4'd1;
        end else if (r_element_count > 4'(LIMIT)) begin
            cnt_eff = 4'(LIMIT);
        end else begin
            cnt_eff = r_element_count;
        end
    end

    assign last_elem = (({1'b0, r_elem} + 4'd1) >= cnt_eff);

    // grid boundaries around the center
    assign t50 = {{2{i_query_time[47]}}, i_query_time};
    assign c50 = {{2{r_center[47]}}, r_center};
    assign d50 = {3'b000, r_step};
    assign lo1 = c50 - d50;
    assign lo2 = c50 - (d50 <<< 1);
    assign up1 = c50 + d50;
    assign up2 = c50 + (d50 <<< 1);
    assign sh_lower = r_lower - {1'b0, r_step};
    assign sh_upper = r_upper + {1'b0, r_step};

    always_comb begin
        case (r_mode)
            MD_LOW: begin
                slot_a = r_slot_lo;
                slot_b = r_slot_ce;
            end
            MD_UP: begin
                slot_a = r_slot_ce;
                slot_b = r_slot_up;
            end
            default: begin
                slot_a = r_slot_ce;
                slot_b = r_slot_ce;
            end
        endcase
    end

    always_comb begin
        case (r_phase)
            PH_RESET: begin
                fetch_slot = r_slot_ce;
                fetch_bit  = 3'b010;
            end
            PH_LO_INTERP, PH_LO_SHIFT: begin
                fetch_slot = r_slot_lo;
                fetch_bit  = 3'b001;
            end
            default: begin
                fetch_slot = r_slot_up;
                fetch_bit  = 3'b100;
            end
        endcase
    end

    // shared multiplier: one 8-bit digit per cycle
    assign acc_sum = r_acc + r_mcand * ACC_W'(r_mplier[7:0]);
    assign term    = SW'(acc_sum);
    assign s2      = r_s + ((r_eb[VW-1] ^ r_fb[FW-1]) ? (~term + SW'(1)) : term);
    assign abs_s   = s2[SW-1] ? (~s2 + SW'(1)) : s2;
    assign q       = acc_sum[103:56];
    assign over    = |acc_sum[ACC_W-1:104];

    always_comb begin
        if (r_s[SW-1]) begin
            if (over || q > 48'h800000000000) begin
                res = 48'h800000000000;
            end else begin
                res = ~q + 48'd1;
            end
        end else if (over || q > 48'h7FFFFFFFFFFF) begin
            res = 48'h7FFFFFFFFFFF;
        end else begin
            res = q;
        end
    end

    always_comb begin
        n_element_count = r_element_count;
        n_step    = r_step;
        n_recip   = r_recip;
        n_lower   = r_lower;
        n_center  = r_center;
        n_upper   = r_upper;
        n_pending = r_pending;
        n_valid   = r_valid;
        n_slot_lo = r_slot_lo;
        n_slot_ce = r_slot_ce;
        n_slot_up = r_slot_up;
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_state   = r_state;
        n_mode    = r_mode;
        n_elem    = r_elem;
        n_dcnt    = r_dcnt;
        n_fa      = r_fa;
        n_fb      = r_fb;
        n_ea      = r_ea;
        n_eb      = r_eb;
        n_mcand   = r_mcand;
        n_mplier  = r_mplier;
        n_acc     = r_acc;
        n_s       = r_s;
        n_strobe  = 1'b0;
        n_kind    = r_kind;
        n_req_time = r_req_time;
        n_value   = r_value;
        n_index   = r_index;
        n_last    = r_last;
        rd_en     = 1'b0;
        rd_addr   = '0;
        wr_en     = 1'b0;
        wr_addr   = AW'(AW'(fetch_slot) * AW'(MAX_ELEMENTS)) + AW'(r_cnt);
        do_req    = 1'b0;
        do_emit   = 1'b0;
        do_shdn   = 1'b0;
        do_shup   = 1'b0;
        req_phase = PH_IDLE;
        req_time  = '0;
        emit_mode = MD_RAW;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ELEMENT_COUNT: n_element_count = i_cfg_data[3:0];
                CFG_STEP_SIZE:     n_step = i_cfg_data[46:0];
                CFG_STEP_RECIP:    n_recip = i_cfg_data;
                default: ;
            endcase
        end

        if (start && !busy) begin
            if (i_opcode) begin
                // sample element of a fetch in progress
                if (r_phase != PH_IDLE) begin
                    wr_en = 1'b1;
                    if (({1'b0, r_cnt} + 4'd1) < cnt_eff) begin
                        n_cnt = r_cnt + 3'd1;
                    end else begin
                        n_cnt   = 3'd0;
                        n_phase = PH_IDLE;
                        n_valid = r_valid | fetch_bit;
                        case (r_phase)
                            PH_RESET: begin
                                do_emit = 1'b1;
                                emit_mode = MD_RAW;
                            end
                            PH_LO_INTERP: begin
                                do_emit = 1'b1;
                                emit_mode = MD_LOW;
                            end
                            PH_LO_SHIFT: do_shdn = 1'b1;
                            PH_UP_INTERP: begin
                                do_emit = 1'b1;
                                emit_mode = MD_UP;
                            end
                            default: do_shup = 1'b1;
                        endcase
                    end
                end
            end else if (r_phase == PH_IDLE) begin
                n_pending = i_query_time;
                if (!r_valid[ROLE_CEN]) begin
                    n_valid = 3'b000;
                    n_center = i_query_time;
                    do_req = 1'b1;
                    req_phase = PH_RESET;
                    req_time = i_query_time;
                end else if (t50 <= c50) begin
                    if (lo1 <= t50) begin
                        if (r_valid[ROLE_LOW]) begin
                            do_emit = 1'b1;
                            emit_mode = MD_LOW;
                        end else begin
                            n_lower = lo1[TW-1:0];
                            do_req = 1'b1;
                            req_phase = PH_LO_INTERP;
                            req_time = lo1[TW-1:0];
                        end
                    end else if (lo2 <= t50) begin
                        if (r_valid[ROLE_LOW]) begin
                            do_shdn = 1'b1;
                        end else begin
                            n_lower = lo1[TW-1:0];
                            do_req = 1'b1;
                            req_phase = PH_LO_SHIFT;
                            req_time = lo1[TW-1:0];
                        end
                    end else begin
                        n_valid = 3'b000;
                        n_center = i_query_time;
                        do_req = 1'b1;
                        req_phase = PH_RESET;
                        req_time = i_query_time;
                    end
                end else begin
                    if (up1 >= t50) begin
                        if (r_valid[ROLE_UP]) begin
                            do_emit = 1'b1;
                            emit_mode = MD_UP;
                        end else begin
                            n_upper = up1[TW-1:0];
                            do_req = 1'b1;
                            req_phase = PH_UP_INTERP;
                            req_time = up1[TW-1:0];
                        end
                    end else if (up2 >= t50) begin
                        if (r_valid[ROLE_UP]) begin
                            do_shup = 1'b1;
                        end else begin
                            n_upper = up1[TW-1:0];
                            do_req = 1'b1;
                            req_phase = PH_UP_SHIFT;
                            req_time = up1[TW-1:0];
                        end
                    end else begin
                        n_valid = 3'b000;
                        n_center = i_query_time;
                        do_req = 1'b1;
                        req_phase = PH_RESET;
                        req_time = i_query_time;
                    end
                end
            end
        end

        // window moves down one step, old upper slot is recycled as lower
        if (do_shdn) begin
            n_slot_lo = r_slot_up;
            n_slot_ce = r_slot_lo;
            n_slot_up = r_slot_ce;
            n_upper   = r_center;
            n_center  = r_lower;
            n_lower   = sh_lower;
            n_valid   = 3'b110;
            do_req    = 1'b1;
            req_phase = PH_LO_INTERP;
            req_time  = sh_lower;
        end
        if (do_shup) begin
            n_slot_lo = r_slot_ce;
            n_slot_ce = r_slot_up;
            n_slot_up = r_slot_lo;
            n_lower   = r_center;
            n_center  = r_upper;
            n_upper   = sh_upper;
            n_valid   = 3'b011;
            do_req    = 1'b1;
            req_phase = PH_UP_INTERP;
            req_time  = sh_upper;
        end
        if (do_req) begin
            n_phase    = req_phase;
            n_cnt      = 3'd0;
            n_strobe   = 1'b1;
            n_kind     = KIND_REQUEST;
            n_req_time = req_time;
            n_value    = '0;
            n_index    = 3'd0;
            n_last     = 1'b1;
        end
        if (do_emit) begin
            n_state = ST_PREP;
            n_mode  = emit_mode;
            n_elem  = 3'd0;
        end

        case (r_state)
            ST_PREP: begin
                if (r_mode == MD_UP) begin
                    n_fa = FW'(signed'(r_upper)) - FW'(signed'(r_pending));
                    n_fb = FW'(signed'(r_pending)) - FW'(signed'(r_center));
                end else begin
                    n_fa = FW'(signed'(r_center)) - FW'(signed'(r_pending));
                    n_fb = FW'(signed'(r_pending)) - FW'(signed'(r_lower));
                end
                rd_en   = 1'b1;
                rd_addr = AW'(AW'(slot_a) * AW'(MAX_ELEMENTS)) + AW'(r_elem);
                n_state = ST_LDA;
            end
            ST_LDA: begin
                if (r_mode == MD_RAW) begin
                    n_strobe   = 1'b1;
                    n_kind     = KIND_ELEMENT;
                    n_req_time = '0;
                    n_value    = r_rd_data;
                    n_index    = r_elem;
                    n_last     = last_elem;
                    if (last_elem) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_elem  = r_elem + 3'd1;
                        n_state = ST_PREP;
                    end
                end else begin
                    n_ea    = r_rd_data;
                    rd_en   = 1'b1;
                    rd_addr = AW'(AW'(slot_b) * AW'(MAX_ELEMENTS)) + AW'(r_elem);
                    n_state = ST_LDB;
                end
            end
            ST_LDB: begin
                n_eb     = r_rd_data;
                n_mcand  = ACC_W'(r_fa[FW-1] ? (~r_fa + FW'(1)) : r_fa);
                n_mplier = r_ea[VW-1] ? (~r_ea + 48'd1) : r_ea;
                n_acc    = '0;
                n_dcnt   = 3'd0;
                n_state  = ST_M1;
            end
            ST_M1, ST_M2, ST_M3: begin
                n_acc    = acc_sum;
                n_mcand  = r_mcand << 8;
                n_mplier = r_mplier >> 8;
                n_dcnt   = r_dcnt + 3'd1;
                if (r_dcnt == 3'(DIGITS - 1)) begin
                    n_acc  = '0;
                    n_dcnt = 3'd0;
                    if (r_state == ST_M1) begin
                        n_s      = (r_ea[VW-1] ^ r_fa[FW-1]) ? (~term + SW'(1)) : term;
                        n_mcand  = ACC_W'(r_fb[FW-1] ? (~r_fb + FW'(1)) : r_fb);
                        n_mplier = r_eb[VW-1] ? (~r_eb + 48'd1) : r_eb;
                        n_state  = ST_M2;
                    end else if (r_state == ST_M2) begin
                        n_s      = s2;
                        n_mcand  = ACC_W'(abs_s);
                        n_mplier = r_recip;
                        n_state  = ST_M3;
                    end else begin
                        n_strobe   = 1'b1;
                        n_kind     = KIND_ELEMENT;
                        n_req_time = '0;
                        n_value    = res;
                        n_index    = r_elem;
                        n_last     = last_elem;
                        if (last_elem) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_elem  = r_elem + 3'd1;
                            n_state = ST_PREP;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_sample_mem[wr_addr] <= i_sample_element;
        end
        if (rd_en) begin
            r_rd_data <= r_sample_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= RST_ELEMENT_COUNT;
            r_step    <= RST_STEP_SIZE;
            r_recip   <= RST_STEP_RECIP;
            r_lower   <= '0;
            r_center  <= '0;
            r_upper   <= '0;
            r_pending <= '0;
            r_valid   <= 3'b000;
            r_slot_lo <= 2'd0;
            r_slot_ce <= 2'd1;
            r_slot_up <= 2'd2;
            r_phase   <= PH_IDLE;
            r_cnt     <= 3'd0;
            r_state   <= ST_IDLE;
            r_mode    <= MD_RAW;
            r_elem    <= 3'd0;
            r_dcnt    <= 3'd0;
            r_strobe  <= 1'b0;
        end else begin
            r_element_count <= n_element_count;
            r_step    <= n_step;
            r_recip   <= n_recip;
            r_lower   <= n_lower;
            r_center  <= n_center;
            r_upper   <= n_upper;
            r_pending <= n_pending;
            r_valid   <= n_valid;
            r_slot_lo <= n_slot_lo;
            r_slot_ce <= n_slot_ce;
            r_slot_up <= n_slot_up;
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_elem    <= n_elem;
            r_dcnt    <= n_dcnt;
            r_strobe  <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fa       <= n_fa;
        r_fb       <= n_fb;
        r_ea       <= n_ea;
        r_eb       <= n_eb;
        r_mcand    <= n_mcand;
        r_mplier   <= n_mplier;
        r_acc      <= n_acc;
        r_s        <= n_s;
        r_kind     <= n_kind;
        r_req_time <= n_req_time;
        r_value    <= n_value;
        r_index    <= n_index;
        r_last     <= n_last;
    end

endmodule
`default_nettype wire
